/* hw/rtl/dqsd_pkg.sv */
// shared types and codes for the deque with search and delete
// no dependencies
`timescale 1ns / 1ps

package dqsd_pkg;

    // width of the packed input transaction (action + operand, padded to bytes)
    localparam int IN_W = 40;
    localparam int DATA_W = 32;
    localparam int ACTION_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REMOVE     = 3'd4,
        ACT_FIND       = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic found;
        logic rejected;
    } reply_t;

endpackage

/* hw/rtl/dqsd_mem.sv */
// value store: one write port, one registered read port
// depends on nothing
`timescale 1ns / 1ps

module dqsd_mem #(
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/dqsd_ctrl.sv */
// request sequencer: ring pointers, count, scan compare and gap close
// depends on dqsd_pkg
`timescale 1ns / 1ps

module dqsd_ctrl #(
    parameter int CAPACITY = 64,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [dqsd_pkg::ACTION_W-1:0] req_action,
    input  logic [dqsd_pkg::DATA_W-1:0]   req_operand,
    output logic                          reply_valid,
    input  logic                          reply_ready,
    output dqsd_pkg::reply_t              reply,
    output logic [CNT_W-1:0]              fill_count,
    output logic                          mem_we,
    output logic [IDX_W-1:0]              mem_waddr,
    output logic [dqsd_pkg::DATA_W-1:0]   mem_wdata,
    output logic [IDX_W-1:0]              mem_raddr,
    input  logic [dqsd_pkg::DATA_W-1:0]   mem_rdata
);

    dqsd_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [IDX_W-1:0] cmp_ptr_reg, cmp_ptr_next;
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    logic             rejected_reg, rejected_next;
    logic             is_remove_reg, is_remove_next;
    logic [dqsd_pkg::DATA_W-1:0] operand_reg, operand_next;

    logic [IDX_W:0]   back_sum;
    logic [IDX_W-1:0] back_pos;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] scan_inc;
    logic             full;
    logic             empty;
    logic             rd_en;
    logic             hit;

    // ring position arithmetic
    assign back_sum  = {1'b0, front_reg} + (IDX_W+1)'(count_reg);
    assign back_pos  = (back_sum >= (IDX_W+1)'(CAPACITY))
                       ? IDX_W'(back_sum - (IDX_W+1)'(CAPACITY)) : IDX_W'(back_sum);
    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == IDX_W'(CAPACITY - 1)) ? '0 : front_reg + IDX_W'(1);
    assign scan_inc  = (scan_ptr_reg == IDX_W'(CAPACITY - 1)) ? '0
                       : scan_ptr_reg + IDX_W'(1);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    // the shared compare unit: one stored entry per cycle
    assign rd_en = ((state_reg == dqsd_pkg::ST_SCAN) || (state_reg == dqsd_pkg::ST_SHIFT))
                   && (idx_reg < count_reg);
    assign hit   = pend_reg && (mem_rdata == operand_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dqsd_pkg::ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        scan_ptr_reg  <= scan_ptr_next;
        cmp_ptr_reg   <= cmp_ptr_next;
        wr_ptr_reg    <= wr_ptr_next;
        found_reg     <= found_next;
        rejected_reg  <= rejected_next;
        is_remove_reg <= is_remove_next;
        operand_reg   <= operand_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        scan_ptr_next  = scan_ptr_reg;
        cmp_ptr_next   = cmp_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        rejected_next  = rejected_reg;
        is_remove_next = is_remove_reg;
        operand_next   = operand_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_ptr_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = scan_ptr_reg;
        req_ready      = 1'b0;
        reply_valid    = 1'b0;

        unique case (state_reg)
            dqsd_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    operand_next   = req_operand;
                    found_next     = 1'b0;
                    rejected_next  = 1'b0;
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    scan_ptr_next  = front_reg;
                    is_remove_next = (req_action == dqsd_pkg::ACT_REMOVE);
                    state_next     = dqsd_pkg::ST_REPLY;
                    unique case (req_action) inside
                        dqsd_pkg::ACT_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                front_next = front_dec;
                                mem_we     = 1'b1;
                                mem_waddr  = front_dec;
                                mem_wdata  = req_operand;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        dqsd_pkg::ACT_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = back_pos;
                                mem_wdata  = req_operand;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        dqsd_pkg::ACT_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        dqsd_pkg::ACT_POP_BACK:
                        begin
                            if (empty)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        dqsd_pkg::ACT_REMOVE, dqsd_pkg::ACT_FIND:
                        begin
                            if (!empty)
                            begin
                                state_next = dqsd_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = dqsd_pkg::ST_REPLY;
                        end
                    endcase
                end
            end

            dqsd_pkg::ST_SCAN:
            begin
                pend_next = rd_en;
                if (rd_en)
                begin
                    idx_next      = idx_reg + CNT_W'(1);
                    scan_ptr_next = scan_inc;
                    cmp_ptr_next  = scan_ptr_reg;
                end
                if (hit)
                begin
                    found_next = 1'b1;
                    if (is_remove_reg)
                    begin
                        // the read already in flight is the first entry to move down
                        wr_ptr_next = cmp_ptr_reg;
                        state_next  = dqsd_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        state_next = dqsd_pkg::ST_REPLY;
                    end
                end
                else if (!rd_en)
                begin
                    state_next = dqsd_pkg::ST_REPLY;
                end
            end

            dqsd_pkg::ST_SHIFT:
            begin
                pend_next = rd_en;
                if (rd_en)
                begin
                    idx_next      = idx_reg + CNT_W'(1);
                    scan_ptr_next = scan_inc;
                    cmp_ptr_next  = scan_ptr_reg;
                end
                if (pend_reg)
                begin
                    mem_we      = 1'b1;
                    wr_ptr_next = cmp_ptr_reg;
                end
                if (!rd_en)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = dqsd_pkg::ST_REPLY;
                end
            end

            dqsd_pkg::ST_REPLY:
            begin
                reply_valid = 1'b1;
                if (reply_ready)
                begin
                    state_next = dqsd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dqsd_pkg::ST_IDLE;
            end
        endcase
    end

    assign reply.found    = found_reg;
    assign reply.rejected = rejected_reg;
    assign fill_count     = count_reg;

endmodule

/* hw/rtl/deque_with_search_and_delete.sv */
// top level of the deque with search and delete: stream ports and reply register
// depends on dqsd_pkg, dqsd_mem, dqsd_ctrl
`timescale 1ns / 1ps

// usage
//   requests arrive on the s_ group, one transaction per request; replies leave
//   on the m_ group, exactly one reply transaction per request, in order
//   push front / push back / pop front / pop back go from accept straight to
//   the reply state
//   remove and find walk the held values from the front through one compare
//   unit at one entry per cycle, then a remove that matches closes the gap at
//   one entry per cycle on the same read pipeline; both rates are set by the
//   single read port of the value store
//   one request is in work at a time; s_tready is low until its reply is
//   registered
//   the reply sits in an output register, so the next request is taken while
//   the receiver still stalls on the previous reply; a stalled m_ side only
//   holds the sequencer once it has a second reply ready
//   reset empties the deque (count and front pointer to zero) with no clearing
//   pass: only held entries are ever read

module deque_with_search_and_delete #(
    parameter int CAPACITY = 64,
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int OUT_W = ((2 + CNT_W + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [2:0] action, [34:3] operand, [39:35] zero
    input  logic [dqsd_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [0] found, [1] rejected, [CNT_W+1:2] fill_count, rest zero
    output logic [OUT_W-1:0]         m_tdata
);

    logic                          reply_valid;
    logic                          reply_ready;
    dqsd_pkg::reply_t              reply;
    logic [CNT_W-1:0]              fill_count;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [dqsd_pkg::DATA_W-1:0]   mem_wdata;
    logic [IDX_W-1:0]              mem_raddr;
    logic [dqsd_pkg::DATA_W-1:0]   mem_rdata;

    logic                          out_valid_reg;
    logic [OUT_W-1:0]              out_data_reg, out_data_next;

    // sequencer with ring pointers and the scan compare
    dqsd_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_action  (s_tdata[dqsd_pkg::ACTION_W-1:0]),
        .req_operand (s_tdata[dqsd_pkg::ACTION_W +: dqsd_pkg::DATA_W]),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply),
        .fill_count  (fill_count),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // circular value store
    dqsd_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .DATA_W (dqsd_pkg::DATA_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // reply register: free when empty or being drained this cycle
    assign reply_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_data_next = '0;
        out_data_next[0] = reply.found;
        out_data_next[1] = reply.rejected;
        out_data_next[2 +: CNT_W] = fill_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (reply_valid && reply_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (reply_valid && reply_ready)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // the held count never exceeds the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // a new request is only taken when no reply is outstanding in the sequencer
    a_ready_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !reply_valid)
        else $error("request accepted while a reply is pending");

    // found and rejected never come together
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("reply both found and rejected");

    // a write to the store only happens with a request in work or just taken
    a_write_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (!s_tready || s_tvalid))
        else $error("store written while idle");
`endif

endmodule
